>>> hw/rtl/smc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sprite mask collision block.
// No dependencies; imported by sprite_mask_collision.
package smc_pkg;

    localparam int EXPL_DIM  = 64;
    localparam int MASK_W    = 64;
    localparam int MASK_ROWS = 64;
    localparam int ROW_AW    = 6;
    localparam int SIZE_W    = 7;
    localparam int CRD_W     = 18;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = 7'd64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] EXPL_SIZE  = SIZE_W'(EXPL_DIM);

    typedef logic signed [CRD_W-1:0] coord_t;
    typedef logic [MASK_W-1:0]       row_t;

    typedef enum logic [1:0] {
        CMD_LOAD_EXPL   = 2'd0,
        CMD_LOAD_TARGET = 2'd1,
        CMD_QUERY       = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_TARGET_SIZE = 1'b0,
        REG_NONE        = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENDS,
        ST_BOUNDS,
        ST_PREP,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

>>> hw/rtl/sprite_mask_collision.sv
`timescale 1ns / 1ps
// Pixel-exact collision test between the explosion and target sprites.
// Depends on smc_pkg for types, command codes and sizes.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  input   | in_valid / in_stall       | cmd, row_index, row_bits, expl_x/y, target_x/y
//  output  | out_valid / out_stall     | box_overlap, hit
//  config  | APB psel/penable/pwrite   | paddr[2] selects target_size, pwdata
//
// A load item writes one mask row. A query item passes through the set-up
// states ST_ENDS, ST_BOUNDS and ST_PREP, then ST_SCAN, which reads one mask row
// per cycle from the two row memories over the intersection height, waits for
// the last registered read and sees the scan drained, and then ST_FINISH, which
// moves the result into the output register. A query with an empty intersection
// skips the scan. Reset sets target_size to 64 and leaves the masks unwritten;
// there is no clearing pass. in_stall is high while a query is in flight, so no
// load can touch a row the scan is reading; a finished result waits in the
// finish state while the output register is still held by out_stall.
module sprite_mask_collision
    import smc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [ROW_AW-1:0]   row_index,
    input  logic [MASK_W-1:0]   row_bits,
    input  logic signed [15:0]  expl_x,
    input  logic signed [15:0]  expl_y,
    input  logic signed [15:0]  target_x,
    input  logic signed [15:0]  target_y,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                box_overlap,
    output logic                hit,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration register
    logic [SIZE_W-1:0] target_size_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_size_reg <= SIZE_RESET;
        end
        else if (cfg_wr && (cfg_idx == REG_TARGET_SIZE))
        begin
            target_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TARGET_SIZE: prdata = {{(32-SIZE_W){1'b0}}, target_size_reg};
            default:         prdata = '0;
        endcase
    end

    // Sequencer
    state_t state_reg, state_next;
    logic   in_acc;
    logic   is_query;
    logic   out_free;
    logic   scan_ok;
    logic   issue_more;
    logic   scan_done;

    logic [ROW_AW:0] issue_cnt_reg;
    logic [ROW_AW:0] row_cnt_reg;
    logic            rd_pend_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign is_query = (cmd_t'(cmd) == CMD_QUERY);
    assign out_free = !out_valid || !out_stall;

    assign issue_more = (issue_cnt_reg != row_cnt_reg);
    assign scan_done  = !issue_more && !rd_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    state_next = ST_ENDS;
                end
            end
            ST_ENDS:   state_next = ST_BOUNDS;
            ST_BOUNDS: state_next = ST_PREP;
            ST_PREP:   state_next = scan_ok ? ST_SCAN : ST_FINISH;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Query positions, held for the whole query
    coord_t q_ex_reg, q_ey_reg, q_tx_reg, q_ty_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && is_query)
        begin
            q_ex_reg <= {{(CRD_W-16){expl_x[15]}},   expl_x};
            q_ey_reg <= {{(CRD_W-16){expl_y[15]}},   expl_y};
            q_tx_reg <= {{(CRD_W-16){target_x[15]}}, target_x};
            q_ty_reg <= {{(CRD_W-16){target_y[15]}}, target_y};
        end
    end

    // Right and bottom edges; clamp the target size to the mask width
    logic [SIZE_W-1:0] ts_clamp;
    coord_t            ts_c, es_c;
    coord_t            t_right_reg, t_bot_reg, e_right_reg, e_bot_reg;

    assign ts_clamp = (target_size_reg > SIZE_MAX) ? SIZE_MAX : target_size_reg;
    assign ts_c     = coord_t'({{(CRD_W-SIZE_W){1'b0}}, ts_clamp});
    assign es_c     = coord_t'({{(CRD_W-SIZE_W){1'b0}}, EXPL_SIZE});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ENDS)
        begin
            t_right_reg <= q_tx_reg + ts_c;
            t_bot_reg   <= q_ty_reg + ts_c;
            e_right_reg <= q_ex_reg + es_c;
            e_bot_reg   <= q_ey_reg + es_c;
        end
    end

    // Strict box test and the intersection rectangle
    logic   overlap_reg;
    coord_t left_reg, right_reg, top_reg, bottom_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BOUNDS)
        begin
            overlap_reg <= (q_ex_reg < t_right_reg) && (q_ey_reg < t_bot_reg) &&
                           (e_right_reg > q_tx_reg) && (e_bot_reg > q_ty_reg);
            left_reg    <= (q_tx_reg > q_ex_reg) ? q_tx_reg : q_ex_reg;
            top_reg     <= (q_ty_reg > q_ey_reg) ? q_ty_reg : q_ey_reg;
            right_reg   <= (t_right_reg < e_right_reg) ? t_right_reg : e_right_reg;
            bottom_reg  <= (t_bot_reg < e_bot_reg) ? t_bot_reg : e_bot_reg;
        end
    end

    // Scan set-up: widths, shifts, first rows
    coord_t            cols_w, rows_w, tsh_w, esh_w, trow_w, erow_w;
    logic [SIZE_W-1:0] cols_n;
    row_t              colmask_n;

    logic [ROW_AW-1:0] tsh_reg, esh_reg, t_row0_reg, e_row0_reg;
    row_t              colmask_reg;

    assign cols_w  = right_reg - left_reg;
    assign rows_w  = bottom_reg - top_reg;
    assign tsh_w   = left_reg - q_tx_reg;
    assign esh_w   = left_reg - q_ex_reg;
    assign trow_w  = top_reg - q_ty_reg;
    assign erow_w  = top_reg - q_ey_reg;
    assign scan_ok = overlap_reg && (cols_w > 0) && (rows_w > 0);
    assign cols_n  = cols_w[SIZE_W-1:0];

    always_comb
    begin
        if (cols_n >= SIZE_W'(MASK_W))
        begin
            colmask_n = '1;
        end
        else
        begin
            colmask_n = (row_t'(1) << cols_n[ROW_AW-1:0]) - row_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            tsh_reg     <= tsh_w[ROW_AW-1:0];
            esh_reg     <= esh_w[ROW_AW-1:0];
            t_row0_reg  <= trow_w[ROW_AW-1:0];
            e_row0_reg  <= erow_w[ROW_AW-1:0];
            colmask_reg <= colmask_n;
        end
    end

    // Row counters: issue one read per cycle, drop the pending flag after
    // the last row has come back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            row_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else if (state_reg == ST_PREP)
        begin
            issue_cnt_reg <= '0;
            row_cnt_reg   <= scan_ok ? rows_w[ROW_AW:0] : '0;
            rd_pend_reg   <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            rd_pend_reg <= issue_more;
            if (issue_more)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
        end
        else
        begin
            rd_pend_reg <= 1'b0;
        end
    end

    // Mask row memories: one write port for loads, one registered read port
    row_t expl_mem   [MASK_ROWS];
    row_t target_mem [MASK_ROWS];
    row_t expl_rd_reg, target_rd_reg;

    logic              we_expl, we_target;
    logic [ROW_AW-1:0] e_raddr, t_raddr;

    assign we_expl   = in_acc && (cmd_t'(cmd) == CMD_LOAD_EXPL);
    assign we_target = in_acc && (cmd_t'(cmd) == CMD_LOAD_TARGET);
    assign e_raddr   = e_row0_reg + issue_cnt_reg[ROW_AW-1:0];
    assign t_raddr   = t_row0_reg + issue_cnt_reg[ROW_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we_expl)
        begin
            expl_mem[row_index] <= row_bits;
        end
        expl_rd_reg <= expl_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_target)
        begin
            target_mem[row_index] <= row_bits;
        end
        target_rd_reg <= target_mem[t_raddr];
    end

    // Align both rows to the intersection's left edge and look for a common pixel
    logic row_hit;
    logic hit_acc_reg;

    assign row_hit = |((target_rd_reg >> tsh_reg) & (expl_rd_reg >> esh_reg) & colmask_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            hit_acc_reg <= 1'b0;
        end
        else if ((state_reg == ST_SCAN) && rd_pend_reg && row_hit)
        begin
            hit_acc_reg <= 1'b1;
        end
    end

    // Output register
    logic out_valid_reg;
    logic box_overlap_reg, hit_reg;
    logic out_load;

    assign out_load = (state_reg == ST_FINISH) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            box_overlap_reg <= overlap_reg;
            hit_reg         <= overlap_reg && hit_acc_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign box_overlap = box_overlap_reg;
    assign hit         = hit_reg;

endmodule

>>> dv/tb_sprite_mask_collision.sv
`timescale 1ns / 1ps
// Testbench for sprite_mask_collision: mask loads, collision queries and the
// target_size register, checked against a cycle-free predictor of the verdicts.
// Depends on smc_pkg and the sprite_mask_collision RTL; self-contained otherwise.
module tb_sprite_mask_collision;
    import smc_pkg::*;

    // Settling time after the last verdict, before any register write or the
    // final verdict.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [2:0] SIZE_ADDR = 3'(4 * int'(REG_TARGET_SIZE));
    localparam logic [2:0] NONE_ADDR = 3'(4 * int'(REG_NONE));

    typedef struct {
        cmd_t               op;
        logic [ROW_AW-1:0]  row;
        logic [MASK_W-1:0]  bits;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } sprite_item_t;

    typedef struct {
        logic box_overlap;
        logic hit;
    } verdict_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          cmd;
    logic [ROW_AW-1:0]   row_index;
    logic [MASK_W-1:0]   row_bits;
    logic signed [15:0]  expl_x;
    logic signed [15:0]  expl_y;
    logic signed [15:0]  target_x;
    logic signed [15:0]  target_y;
    logic                out_valid;
    logic                out_stall;
    logic                box_overlap;
    logic                hit;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor state: our own copy of both masks and of the size register.
    row_t                expl_rows [MASK_ROWS];
    row_t                target_rows [MASK_ROWS];
    logic [SIZE_W-1:0]   model_size;
    verdict_t            pending_verdicts [$];

    int                  mismatch_count;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_req;
    int                  hold_left;

    sprite_mask_collision dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .expl_x      (expl_x),
        .expl_y      (expl_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .box_overlap (box_overlap),
        .hit         (hit),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bounding-square test, then a row-by-row AND over the intersection.
    function automatic verdict_t judge_collision(input logic signed [15:0] ex16,
                                                 input logic signed [15:0] ey16,
                                                 input logic signed [15:0] tx16,
                                                 input logic signed [15:0] ty16);
        verdict_t    v;
        int          ex, ey, tx, ty, ts, es;
        int          left, right, top, bottom, cols, r, tsh, esh;
        logic [63:0] colmask, trow, erow;
        ex = ex16;
        ey = ey16;
        tx = tx16;
        ty = ty16;
        // Sizes above the mask width clamp to 64.
        ts = (model_size > SIZE_MAX) ? 64 : int'(model_size);
        es = EXPL_DIM;
        v.box_overlap = (ex < tx + ts) && (ey < ty + ts) && (ex + es > tx) && (ey + es > ty);
        v.hit = 1'b0;
        if (v.box_overlap)
        begin
            left   = (tx > ex) ? tx : ex;
            right  = (tx + ts < ex + es) ? tx + ts : ex + es;
            top    = (ty > ey) ? ty : ey;
            bottom = (ty + ts < ey + es) ? ty + ts : ey + es;
            cols   = right - left;
            // A zero-size target overlaps by the strict test but has no pixels.
            if (cols > 0 && bottom > top)
            begin
                colmask = (cols >= 64) ? '1 : ((64'd1 << cols) - 64'd1);
                tsh = (left - tx) & 63;
                esh = (left - ex) & 63;
                for (r = top; r < bottom && !v.hit; r++)
                begin
                    trow = target_rows[(r - ty) & 63] >> tsh;
                    erow = expl_rows[(r - ey) & 63] >> esh;
                    if ((trow & erow & colmask) != 64'd0)
                        v.hit = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // Mix dense, sparse, single-bit, empty and full rows so misses happen too.
    function automatic row_t random_row();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return {$urandom(), $urandom()};
        else if (pick < 65)
            return {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
        else if (pick < 75)
            return 64'd1 << $urandom_range(0, 63);
        else if (pick < 85)
            return '0;
        else if (pick < 92)
            return '1;
        else
            return {$urandom(), $urandom()} & {$urandom(), $urandom()} &
                   {$urandom(), $urandom()} & {$urandom(), $urandom()} &
                   {$urandom(), $urandom()};
    endfunction

    function automatic sprite_item_t load_item(input cmd_t op, input int row, input row_t bits);
        sprite_item_t it;
        it.op   = op;
        it.row  = ROW_AW'(row);
        it.bits = bits;
        it.ex   = 16'($urandom());
        it.ey   = 16'($urandom());
        it.tx   = 16'($urandom());
        it.ty   = 16'($urandom());
        return it;
    endfunction

    function automatic sprite_item_t query_item(input int ex, input int ey,
                                                input int tx, input int ty);
        sprite_item_t it;
        it.op   = CMD_QUERY;
        it.row  = ROW_AW'($urandom());
        it.bits = {$urandom(), $urandom()};
        it.ex   = 16'(ex);
        it.ey   = 16'(ey);
        it.tx   = 16'(tx);
        it.ty   = 16'(ty);
        return it;
    endfunction

    // Loads, unused commands and queries; most queries put the squares close together, so that touching,
    // partial and full overlaps all come up; the rest far apart or at extremes.
    function automatic sprite_item_t random_item();
        sprite_item_t it;
        int           pick, ex, ey;
        int           corners [4];
        corners = '{-32768, 32767, 0, -1};
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            it = load_item(CMD_UNUSED, $urandom_range(0, 63), {$urandom(), $urandom()});
        end
        else if (pick < 25)
        begin
            it = load_item(CMD_LOAD_EXPL, $urandom_range(0, 63), random_row());
        end
        else if (pick < 45)
        begin
            it = load_item(CMD_LOAD_TARGET, $urandom_range(0, 63), random_row());
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                ex = $urandom_range(0, 64000) - 32000;
                ey = $urandom_range(0, 64000) - 32000;
                it = query_item(ex, ey, ex + $urandom_range(0, 140) - 70,
                                ey + $urandom_range(0, 140) - 70);
            end
            else if (pick < 90)
            begin
                it = query_item($signed(16'($urandom())), $signed(16'($urandom())),
                                $signed(16'($urandom())), $signed(16'($urandom())));
            end
            else
            begin
                it = query_item(corners[$urandom_range(0, 3)], corners[$urandom_range(0, 3)],
                                corners[$urandom_range(0, 3)], corners[$urandom_range(0, 3)]);
            end
        end
        return it;
    endfunction

    // Offer one item, hold it until accepted, then advance the predictor.
    task automatic send_item(input sprite_item_t it);
        verdict_t v;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd       = it.op;
        row_index = it.row;
        row_bits  = it.bits;
        expl_x    = it.ex;
        expl_y    = it.ey;
        target_x  = it.tx;
        target_y  = it.ty;
        do
            @(posedge clk);
        while (in_stall);
        case (it.op)
            CMD_LOAD_EXPL:   expl_rows[it.row] = it.bits;
            CMD_LOAD_TARGET: target_rows[it.row] = it.bits;
            CMD_QUERY:
            begin
                v = judge_collision(it.ex, it.ey, it.tx, it.ty);
                pending_verdicts.push_back(v);
            end
            default: ;
        endcase
    endtask

    // Drop valid, let every expected verdict arrive, then let the block settle.
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_size_readback();
        logic [31:0] data;
        apb_read(SIZE_ADDR, data);
        if (data[SIZE_W-1:0] !== model_size)
        begin
            $display("%0t: target_size read expected %0d got %0d",
                     $time, model_size, data[SIZE_W-1:0]);
            mismatch_count++;
        end
    endtask

    task automatic set_target_size(input logic [SIZE_W-1:0] size);
        logic [31:0] data;
        wait_drain();
        // Junk in the upper data bits must be ignored.
        data = $urandom();
        data[SIZE_W-1:0] = size;
        apb_write(SIZE_ADDR, data);
        model_size = size;
        check_size_readback();
    endtask

    task automatic test_register_reset();
        check_size_readback();
    endtask

    task automatic test_unmapped_register();
        wait_drain();
        apb_write(NONE_ADDR, $urandom());
        check_size_readback();
    endtask

    // Write every row of both masks, so no later query reads an unwritten row.
    task automatic test_mask_loads();
        int r;
        for (r = 0; r < MASK_ROWS; r++)
        begin
            send_item(load_item(CMD_LOAD_EXPL, r, random_row()));
            send_item(load_item(CMD_LOAD_TARGET, r, random_row()));
        end
    endtask

    task automatic test_directed();
        send_item(load_item(CMD_LOAD_EXPL, 0, '1));
        send_item(load_item(CMD_LOAD_EXPL, 63, 64'h8000_0000_0000_0001));
        send_item(load_item(CMD_LOAD_TARGET, 0, '1));
        send_item(load_item(CMD_LOAD_TARGET, 63, '0));
        // The unused command must change nothing and yield no verdict.
        send_item(load_item(CMD_UNUSED, 0, '1));
        send_item(query_item(0, 0, 0, 0));
        send_item(query_item(-32768, -32768, -32768, -32768));
        send_item(query_item(32767, 32767, 32767, 32767));
        // Edges that only touch are not an overlap.
        send_item(query_item(0, 0, 64, 0));
        send_item(query_item(0, 0, 0, 64));
        send_item(query_item(0, 0, -64, 0));
        // One-pixel corners: visible in both masks, then visible in one only.
        send_item(query_item(0, 0, 63, 63));
        send_item(query_item(0, 0, -63, -63));
        send_item(query_item(32767, 0, -32768, 0));
        send_item(query_item(-32768, -32768, 32767, 32767));
        send_item(query_item(10, -5, 20, 7));
    endtask

    task automatic test_random_traffic(input int n, input int sidle, input int ridle);
        sprite_item_t it;
        int           sent;
        send_idle_pct  = sidle;
        recv_stall_pct = ridle;
        sent = 0;
        while (sent < n)
        begin
            it = random_item();
            send_item(it);
            if (it.op != CMD_UNUSED)
                sent++;
        end
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // block fills and stalls its input; then pause until all verdicts are in and send more.
    task automatic test_output_backpressure();
        sprite_item_t it;
        int           k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_req = 400;
        for (k = 0; k < 40; k++)
        begin
            it = random_item();
            send_item(it);
        end
        wait_drain();
        for (k = 0; k < 20; k++)
        begin
            it = random_item();
            send_item(it);
        end
    endtask

    // Output stall: random, or held high for a requested stretch.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted verdict with the oldest one predicted.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict box_overlap=%0b hit=%0b",
                         $time, box_overlap, hit);
                mismatch_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (box_overlap !== want.box_overlap)
                begin
                    $display("%0t: box_overlap expected %0b got %0b",
                             $time, want.box_overlap, box_overlap);
                    mismatch_count++;
                end
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b got %0b", $time, want.hit, hit);
                    mismatch_count++;
                end
            end
        end
    end

    // Give up on a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_LOAD_EXPL;
        row_index      = '0;
        row_bits       = '0;
        expl_x         = '0;
        expl_y         = '0;
        target_x       = '0;
        target_y       = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        model_size     = SIZE_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        hold_left      = 0;
        foreach (expl_rows[i])
        begin
            expl_rows[i]   = '0;
            target_rows[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_mask_loads();
        send_idle_pct  = 7;
        recv_stall_pct = 52;
        test_directed();
        test_random_traffic(300, 7, 52);
        set_target_size(7'd1);
        test_random_traffic(200, 7, 52);
        test_unmapped_register();
        set_target_size(SIZE_W'($urandom_range(2, 63)));
        test_random_traffic(300, 52, 7);
        set_target_size(7'd127);
        test_random_traffic(150, 52, 7);
        set_target_size(7'd0);
        test_random_traffic(100, 0, 0);
        set_target_size(SIZE_MAX);
        test_output_backpressure();
        set_target_size(SIZE_W'($urandom_range(1, 64)));
        test_random_traffic(300, 0, 0);
        wait_drain();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
